// ===== sv/tldt_pkg.sv =====
// Package for the two-level directory table: sizes, codes, request and
// response types, and the control groups between the sequencer and the RAMs.
// No dependencies.
`default_nettype none

package tldt_pkg;

    localparam int MAX_DIRS      = 16;
    localparam int FILES_PER_DIR = 16;
    localparam int NAME_BITS     = 64;
    localparam int KEY_W         = 64;
    localparam int SLOT_W        = 4;

    localparam int DIR_IDX_W   = (MAX_DIRS > 1) ? $clog2(MAX_DIRS) : 1;
    localparam int DIR_CNT_W   = $clog2(MAX_DIRS + 1);
    localparam int FILE_IDX_W  = (FILES_PER_DIR > 1) ? $clog2(FILES_PER_DIR) : 1;
    localparam int FILE_CNT_W  = $clog2(FILES_PER_DIR + 1);
    localparam int FILE_ADDR_W = DIR_IDX_W + FILE_IDX_W;
    localparam int FILE_DEPTH  = MAX_DIRS << FILE_IDX_W;

    typedef enum logic [1:0] {
        ACT_MKDIR  = 2'd0,
        ACT_MKFILE = 2'd1,
        ACT_DELETE = 2'd2,
        ACT_SEARCH = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        ST_DONE         = 3'd0,
        ST_DIR_FULL     = 3'd1,
        ST_DIR_EXISTS   = 3'd2,
        ST_DIR_MISSING  = 3'd3,
        ST_FILE_LIMIT   = 3'd4,
        ST_FILE_EXISTS  = 3'd5,
        ST_FILE_MISSING = 3'd6,
        ST_FOUND        = 3'd7
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIR,
        S_FILE,
        S_DEL_RD,
        S_DEL_WR,
        S_RESP
    } t_state;

    typedef struct packed {
        logic [1:0]       action;
        logic [KEY_W-1:0] dir_key;
        logic [KEY_W-1:0] file_key;
    } t_req;

    typedef struct packed {
        t_status           status;
        logic [SLOT_W-1:0] dir_slot;
        logic [SLOT_W-1:0] file_slot;
    } t_rsp;

    typedef struct packed {
        logic [NAME_BITS-1:0]  name;
        logic [FILE_CNT_W-1:0] total;
    } t_dir_entry;

    typedef struct packed {
        logic                 en;
        logic [DIR_IDX_W-1:0] addr;
        t_dir_entry           entry;
    } t_dir_wr;

    typedef struct packed {
        logic                 en;
        logic [DIR_IDX_W-1:0] addr;
    } t_dir_rd;

    typedef struct packed {
        logic                   en;
        logic [FILE_ADDR_W-1:0] addr;
        logic [NAME_BITS-1:0]   name;
    } t_file_wr;

    typedef struct packed {
        logic                   en;
        logic [FILE_ADDR_W-1:0] addr;
    } t_file_rd;

    function automatic logic [SLOT_W-1:0] dir_slot_out(input logic [DIR_IDX_W-1:0] idx);
        logic [DIR_IDX_W+SLOT_W-1:0] ext;
        ext = {{SLOT_W{1'b0}}, idx};
        return ext[SLOT_W-1:0];
    endfunction

    function automatic logic [SLOT_W-1:0] file_slot_out(input logic [FILE_IDX_W-1:0] idx);
        logic [FILE_IDX_W+SLOT_W-1:0] ext;
        ext = {{SLOT_W{1'b0}}, idx};
        return ext[SLOT_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== sv/tldt_if.sv =====
// Valid/ready channel interfaces for directory table requests and responses.
// Depends on tldt_pkg.
`default_nettype none

interface tldt_req_if;
    logic              valid;
    logic              ready;
    tldt_pkg::t_req    data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface tldt_rsp_if;
    logic              valid;
    logic              ready;
    tldt_pkg::t_rsp    data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== sv/two_level_directory_table_unit.sv =====
// Two-level directory table. A request creates a directory, creates a file,
// deletes a file or searches for a file, and yields one response with a status
// and the slots involved. Requests are handled one at a time. The directory
// slots are searched linearly, one RAM read and one compare per cycle, and then
// the files of the matched directory the same way; the read port of each RAM
// sets that pace. A delete then reads the last file of the directory and moves
// it into the freed slot. The RAMs need no clearing after reset; the block
// takes a request in the first cycle after reset. A finished response waits in
// an output register while the next request is taken.
// Depends on tldt_pkg, tldt_if, tldt_dir_ram and tldt_file_ram.
`default_nettype none

module two_level_directory_table_unit (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    tldt_req_if.sink   i_req,
    tldt_rsp_if.source o_rsp
);

    localparam int DIR_IDX_W  = tldt_pkg::DIR_IDX_W;
    localparam int DIR_CNT_W  = tldt_pkg::DIR_CNT_W;
    localparam int FILE_IDX_W = tldt_pkg::FILE_IDX_W;
    localparam int FILE_CNT_W = tldt_pkg::FILE_CNT_W;
    localparam int NAME_BITS  = tldt_pkg::NAME_BITS;

    tldt_pkg::t_state  r_state, n_state;
    tldt_pkg::t_action r_action;
    logic [NAME_BITS-1:0] r_dkey, r_fkey;

    logic [DIR_CNT_W-1:0]  r_dir_total, n_dir_total;
    logic [DIR_CNT_W-1:0]  r_didx, n_didx;
    logic                  r_drd_vld, n_drd_vld;
    logic [DIR_IDX_W-1:0]  r_drd_idx, n_drd_idx;
    logic [FILE_CNT_W-1:0] r_fidx, n_fidx;
    logic                  r_frd_vld, n_frd_vld;
    logic [FILE_IDX_W-1:0] r_frd_idx, n_frd_idx;
    logic [FILE_CNT_W-1:0] r_ftotal, n_ftotal;
    tldt_pkg::t_status     r_status, n_status;
    logic [DIR_IDX_W-1:0]  r_dslot, n_dslot;
    logic [FILE_IDX_W-1:0] r_fslot, n_fslot;
    logic                  r_out_valid, n_out_valid;
    tldt_pkg::t_rsp        r_out, n_out;

    tldt_pkg::t_dir_wr    dir_wr;
    tldt_pkg::t_dir_rd    dir_rd;
    tldt_pkg::t_dir_entry dir_rd_data;
    tldt_pkg::t_file_wr   file_wr;
    tldt_pkg::t_file_rd   file_rd;
    logic [NAME_BITS-1:0] file_rd_name;

    logic req_acc, rsp_push;
    logic dir_issue, dir_hit, dir_full, file_issue, file_hit, file_full;
    logic is_mkdir, is_mkfile, is_delete;
    logic [FILE_CNT_W-1:0] ftotal_dec, ftotal_inc;

    tldt_dir_ram u_dir_ram (
        .i_clk     (i_clk),
        .i_wr      (dir_wr),
        .i_rd      (dir_rd),
        .o_rd_data (dir_rd_data)
    );

    tldt_file_ram u_file_ram (
        .i_clk     (i_clk),
        .i_wr      (file_wr),
        .i_rd      (file_rd),
        .o_rd_name (file_rd_name)
    );

    assign i_req.ready = (r_state == tldt_pkg::S_IDLE);
    assign o_rsp.valid = r_out_valid;
    assign o_rsp.data  = r_out;

    assign req_acc  = i_req.valid && i_req.ready;
    assign rsp_push = (r_state == tldt_pkg::S_RESP) && (!r_out_valid || o_rsp.ready);

    assign is_mkdir  = (r_action == tldt_pkg::ACT_MKDIR);
    assign is_mkfile = (r_action == tldt_pkg::ACT_MKFILE);
    assign is_delete = (r_action == tldt_pkg::ACT_DELETE);

    assign dir_issue  = (r_didx < r_dir_total);
    assign dir_hit    = r_drd_vld && (dir_rd_data.name == r_dkey);
    assign dir_full   = (r_dir_total >= DIR_CNT_W'(tldt_pkg::MAX_DIRS));
    assign file_full  = (dir_rd_data.total >= FILE_CNT_W'(tldt_pkg::FILES_PER_DIR));
    assign file_issue = (r_fidx < r_ftotal);
    assign file_hit   = r_frd_vld && (file_rd_name == r_fkey);
    assign ftotal_dec = r_ftotal - 1'b1;
    assign ftotal_inc = r_ftotal + 1'b1;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            tldt_pkg::S_IDLE: begin
                if (req_acc) begin
                    n_state = tldt_pkg::S_DIR;
                end
            end
            tldt_pkg::S_DIR: begin
                priority if (is_mkdir && dir_full) begin
                    n_state = tldt_pkg::S_RESP;
                end else if (dir_hit) begin
                    if (is_mkdir || (is_mkfile && file_full)) begin
                        n_state = tldt_pkg::S_RESP;
                    end else begin
                        n_state = tldt_pkg::S_FILE;
                    end
                end else if (!dir_issue) begin
                    n_state = tldt_pkg::S_RESP;
                end else begin
                    n_state = tldt_pkg::S_DIR;
                end
            end
            tldt_pkg::S_FILE: begin
                priority if (file_hit) begin
                    n_state = is_delete ? tldt_pkg::S_DEL_RD : tldt_pkg::S_RESP;
                end else if (!file_issue) begin
                    n_state = tldt_pkg::S_RESP;
                end else begin
                    n_state = tldt_pkg::S_FILE;
                end
            end
            tldt_pkg::S_DEL_RD: n_state = tldt_pkg::S_DEL_WR;
            tldt_pkg::S_DEL_WR: n_state = tldt_pkg::S_RESP;
            tldt_pkg::S_RESP: begin
                if (rsp_push) begin
                    n_state = tldt_pkg::S_IDLE;
                end
            end
            default: n_state = tldt_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        n_dir_total = r_dir_total;
        n_didx      = r_didx;
        n_drd_vld   = r_drd_vld;
        n_drd_idx   = r_drd_idx;
        n_fidx      = r_fidx;
        n_frd_vld   = r_frd_vld;
        n_frd_idx   = r_frd_idx;
        n_ftotal    = r_ftotal;
        n_status    = r_status;
        n_dslot     = r_dslot;
        n_fslot     = r_fslot;
        n_out_valid = r_out_valid && !o_rsp.ready;
        n_out       = r_out;
        dir_wr      = '0;
        dir_rd      = '0;
        file_wr     = '0;
        file_rd     = '0;
        unique case (r_state)
            tldt_pkg::S_IDLE: begin
                if (req_acc) begin
                    n_didx    = '0;
                    n_drd_vld = 1'b0;
                    n_fidx    = '0;
                    n_frd_vld = 1'b0;
                    n_status  = tldt_pkg::ST_DONE;
                    n_dslot   = '0;
                    n_fslot   = '0;
                end
            end
            tldt_pkg::S_DIR: begin
                dir_rd.en   = dir_issue;
                dir_rd.addr = r_didx[DIR_IDX_W-1:0];
                n_drd_vld   = dir_issue;
                n_drd_idx   = r_didx[DIR_IDX_W-1:0];
                if (dir_issue) begin
                    n_didx = r_didx + 1'b1;
                end
                priority if (is_mkdir && dir_full) begin
                    n_status = tldt_pkg::ST_DIR_FULL;
                end else if (dir_hit) begin
                    n_dslot  = r_drd_idx;
                    n_ftotal = dir_rd_data.total;
                    if (is_mkdir) begin
                        n_status = tldt_pkg::ST_DIR_EXISTS;
                    end else if (is_mkfile && file_full) begin
                        n_status = tldt_pkg::ST_FILE_LIMIT;
                    end
                end else if (!dir_issue) begin
                    if (is_mkdir) begin
                        dir_wr.en          = 1'b1;
                        dir_wr.addr        = r_dir_total[DIR_IDX_W-1:0];
                        dir_wr.entry.name  = r_dkey;
                        dir_wr.entry.total = '0;
                        n_dir_total        = r_dir_total + 1'b1;
                        n_dslot            = r_dir_total[DIR_IDX_W-1:0];
                    end else begin
                        n_status = tldt_pkg::ST_DIR_MISSING;
                    end
                end else begin
                    n_status = r_status;
                end
            end
            tldt_pkg::S_FILE: begin
                file_rd.en   = file_issue;
                file_rd.addr = {r_dslot, r_fidx[FILE_IDX_W-1:0]};
                n_frd_vld    = file_issue;
                n_frd_idx    = r_fidx[FILE_IDX_W-1:0];
                if (file_issue) begin
                    n_fidx = r_fidx + 1'b1;
                end
                priority if (file_hit) begin
                    n_fslot = r_frd_idx;
                    unique case (r_action)
                        tldt_pkg::ACT_MKFILE: n_status = tldt_pkg::ST_FILE_EXISTS;
                        tldt_pkg::ACT_SEARCH: n_status = tldt_pkg::ST_FOUND;
                        tldt_pkg::ACT_DELETE: n_status = tldt_pkg::ST_DONE;
                        tldt_pkg::ACT_MKDIR:  n_status = tldt_pkg::ST_DIR_EXISTS;
                    endcase
                end else if (!file_issue) begin
                    if (is_mkfile) begin
                        file_wr.en         = 1'b1;
                        file_wr.addr       = {r_dslot, r_ftotal[FILE_IDX_W-1:0]};
                        file_wr.name       = r_fkey;
                        dir_wr.en          = 1'b1;
                        dir_wr.addr        = r_dslot;
                        dir_wr.entry.name  = r_dkey;
                        dir_wr.entry.total = ftotal_inc;
                        n_fslot            = r_ftotal[FILE_IDX_W-1:0];
                    end else begin
                        n_status = tldt_pkg::ST_FILE_MISSING;
                    end
                end else begin
                    n_status = r_status;
                end
            end
            tldt_pkg::S_DEL_RD: begin
                file_rd.en   = 1'b1;
                file_rd.addr = {r_dslot, ftotal_dec[FILE_IDX_W-1:0]};
            end
            tldt_pkg::S_DEL_WR: begin
                file_wr.en         = 1'b1;
                file_wr.addr       = {r_dslot, r_fslot};
                file_wr.name       = file_rd_name;
                dir_wr.en          = 1'b1;
                dir_wr.addr        = r_dslot;
                dir_wr.entry.name  = r_dkey;
                dir_wr.entry.total = ftotal_dec;
            end
            tldt_pkg::S_RESP: begin
                if (rsp_push) begin
                    n_out_valid     = 1'b1;
                    n_out.status    = r_status;
                    n_out.dir_slot  = tldt_pkg::dir_slot_out(r_dslot);
                    n_out.file_slot = tldt_pkg::file_slot_out(r_fslot);
                end
            end
            default: begin
                n_status = r_status;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tldt_pkg::S_IDLE;
            r_dir_total <= '0;
            r_drd_vld   <= 1'b0;
            r_frd_vld   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_dir_total <= n_dir_total;
            r_drd_vld   <= n_drd_vld;
            r_frd_vld   <= n_frd_vld;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (req_acc) begin
            r_action <= tldt_pkg::t_action'(i_req.data.action);
            r_dkey   <= i_req.data.dir_key[NAME_BITS-1:0];
            r_fkey   <= i_req.data.file_key[NAME_BITS-1:0];
        end
        r_didx    <= n_didx;
        r_drd_idx <= n_drd_idx;
        r_fidx    <= n_fidx;
        r_frd_idx <= n_frd_idx;
        r_ftotal  <= n_ftotal;
        r_status  <= n_status;
        r_dslot   <= n_dslot;
        r_fslot   <= n_fslot;
        r_out     <= n_out;
    end

endmodule

`default_nettype wire

// ===== sv/tldt_dir_ram.sv =====
// Directory RAM: one name and one file count per directory slot, one write
// and one registered read per cycle. Depends on tldt_pkg.
`default_nettype none

module tldt_dir_ram (
    input  wire logic                  i_clk,
    input  wire tldt_pkg::t_dir_wr     i_wr,
    input  wire tldt_pkg::t_dir_rd     i_rd,
    output tldt_pkg::t_dir_entry       o_rd_data
);

    tldt_pkg::t_dir_entry r_mem [tldt_pkg::MAX_DIRS];
    tldt_pkg::t_dir_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.entry;
        end
        if (i_rd.en) begin
            r_rd_data <= r_mem[i_rd.addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// ===== sv/tldt_file_ram.sv =====
// File name RAM, addressed by directory slot and file slot, one write and one
// registered read per cycle. Depends on tldt_pkg.
`default_nettype none

module tldt_file_ram (
    input  wire logic                           i_clk,
    input  wire tldt_pkg::t_file_wr             i_wr,
    input  wire tldt_pkg::t_file_rd             i_rd,
    output logic [tldt_pkg::NAME_BITS-1:0]      o_rd_name
);

    logic [tldt_pkg::NAME_BITS-1:0] r_mem [tldt_pkg::FILE_DEPTH];
    logic [tldt_pkg::NAME_BITS-1:0] r_rd_name;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.name;
        end
        if (i_rd.en) begin
            r_rd_name <= r_mem[i_rd.addr];
        end
    end

    assign o_rd_name = r_rd_name;

endmodule

`default_nettype wire

// ===== sv/tldt_checker.sv =====
// Port-level checks for the directory table, attached by bind to the top
// level. Depends on tldt_pkg and two_level_directory_table_unit.
`default_nettype none

module tldt_checker (
    input wire logic           i_clk,
    input wire logic           i_rst_n,
    input wire logic           i_req_valid,
    input wire logic           i_req_ready,
    input wire logic           i_rsp_valid,
    input wire logic           i_rsp_ready,
    input wire tldt_pkg::t_rsp i_rsp_data
);

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !i_rsp_valid)
        else $error("A response is offered right after reset.");

    a_one_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && i_req_ready) |=> !i_req_ready)
        else $error("A second request is taken while one is in progress.");

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && !i_rsp_ready) |=> (i_rsp_valid && $stable(i_rsp_data)))
        else $error("A stalled response changed or was dropped.");

    a_dir_fail_slots: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && (i_rsp_data.status == tldt_pkg::ST_DIR_FULL ||
                         i_rsp_data.status == tldt_pkg::ST_DIR_MISSING))
        |-> (i_rsp_data.dir_slot == '0 && i_rsp_data.file_slot == '0))
        else $error("A failed directory lookup reports a slot.");

    a_file_fail_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && (i_rsp_data.status == tldt_pkg::ST_FILE_LIMIT ||
                         i_rsp_data.status == tldt_pkg::ST_FILE_MISSING))
        |-> (i_rsp_data.file_slot == '0))
        else $error("A failed file request reports a file slot.");

endmodule

bind two_level_directory_table_unit tldt_checker u_tldt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req.valid),
    .i_req_ready (i_req.ready),
    .i_rsp_valid (o_rsp.valid),
    .i_rsp_ready (o_rsp.ready),
    .i_rsp_data  (o_rsp.data)
);

`default_nettype wire
